// ===== rtl/fbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants of the frustum box cull block
// Matrix entry and plane coefficient types, operation codes and defaults.
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int ENTRY_W       = 32;
    localparam int NORM_W        = ENTRY_W + 1;
    localparam int NUM_ROWS      = 4;
    localparam int NUM_PLANES    = 6;
    localparam int NUM_AXES      = 3;

    localparam int BOX_EDGE_DEF  = 16;
    localparam int CELL_BITS_DEF = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef entry_t [15:0]             matrix_t;
    typedef logic signed [NORM_W-1:0]  norm_t;
    typedef norm_t [NUM_AXES-1:0]      norm3_t;
    typedef norm3_t [NUM_PLANES-1:0]   plane_norm_t;
    typedef norm_t [NUM_PLANES-1:0]    plane_off_t;

    // Entry m_rk sits at index r*4+k.
    function automatic logic [3:0] entry_index(input logic [1:0] row, input logic [1:0] grp);
        entry_index = {row, grp};
    endfunction

endpackage

// ===== rtl/fbc_matrix_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_matrix_store: projection-view matrix register file
// Holds sixteen entries; a load writes one group k (entries m0k to m3k).
// ----------------------------------------------------------------------------
module fbc_matrix_store (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [1:0]       wr_group,
    input  fbc_pkg::entry_t  wr_x,
    input  fbc_pkg::entry_t  wr_y,
    input  fbc_pkg::entry_t  wr_z,
    input  fbc_pkg::entry_t  wr_w,
    output fbc_pkg::matrix_t matrix
);
    import fbc_pkg::*;

    matrix_t m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= '0;
        end
        else if (wr_en)
        begin
            m_reg[entry_index(2'd0, wr_group)] <= wr_x;
            m_reg[entry_index(2'd1, wr_group)] <= wr_y;
            m_reg[entry_index(2'd2, wr_group)] <= wr_z;
            m_reg[entry_index(2'd3, wr_group)] <= wr_w;
        end
    end

    assign matrix = m_reg;

endmodule

// ===== rtl/fbc_plane_form.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_plane_form: first pipeline stage
// Forms the six clip planes from the matrix and scales the cell coordinates.
// ----------------------------------------------------------------------------
module fbc_plane_form #(
    parameter int BOX_EDGE  = fbc_pkg::BOX_EDGE_DEF,
    parameter int CELL_BITS = fbc_pkg::CELL_BITS_DEF,
    parameter int P_W       = CELL_BITS + $clog2(BOX_EDGE) + 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  fbc_pkg::matrix_t            matrix,
    input  logic signed [CELL_BITS-1:0] cell_x,
    input  logic signed [CELL_BITS-1:0] cell_y,
    input  logic signed [CELL_BITS-1:0] cell_z,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output fbc_pkg::plane_norm_t        normal,
    output fbc_pkg::plane_off_t         offset,
    output logic signed [P_W-1:0]       p_lo [3]
);
    import fbc_pkg::*;

    localparam logic signed [P_W-1:0] EDGE_P = P_W'(BOX_EDGE);

    logic                  valid_reg;
    plane_norm_t           normal_reg;
    plane_norm_t           normal_next;
    plane_off_t            offset_reg;
    plane_off_t            offset_next;
    logic signed [P_W-1:0] p_lo_reg [3];
    logic signed [P_W-1:0] cell_ext [3];
    logic                  load_en;

    assign up_ready = !valid_reg || dn_ready;
    assign load_en  = up_valid && up_ready;

    assign cell_ext[0] = P_W'(cell_x);
    assign cell_ext[1] = P_W'(cell_y);
    assign cell_ext[2] = P_W'(cell_z);

    // Plane 2k is m_3 + m_k, plane 2k+1 is m_3 - m_k, per row.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                normal_next[2*k][r] =
                    NORM_W'($signed(matrix[entry_index(2'(r), 2'd3)])) +
                    NORM_W'($signed(matrix[entry_index(2'(r), 2'(k))]));
                normal_next[2*k+1][r] =
                    NORM_W'($signed(matrix[entry_index(2'(r), 2'd3)])) -
                    NORM_W'($signed(matrix[entry_index(2'(r), 2'(k))]));
            end
            offset_next[2*k] =
                NORM_W'($signed(matrix[entry_index(2'd3, 2'd3)])) +
                NORM_W'($signed(matrix[entry_index(2'd3, 2'(k))]));
            offset_next[2*k+1] =
                NORM_W'($signed(matrix[entry_index(2'd3, 2'd3)])) -
                NORM_W'($signed(matrix[entry_index(2'd3, 2'(k))]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            normal_reg <= normal_next;
            offset_reg <= offset_next;
            for (int r = 0; r < 3; r++)
            begin
                p_lo_reg[r] <= cell_ext[r] * EDGE_P;
            end
        end
    end

    assign dn_valid = valid_reg;
    assign normal   = normal_reg;
    assign offset   = offset_reg;
    assign p_lo     = p_lo_reg;

endmodule

// ===== rtl/fbc_plane_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_plane_dist: corner selection, products and plane distances
// Stage two multiplies each normal component by its far corner coordinate;
// stage three sums the products with the offset and keeps the sign.
// ----------------------------------------------------------------------------
module fbc_plane_dist #(
    parameter int BOX_EDGE = fbc_pkg::BOX_EDGE_DEF,
    parameter int P_W      = fbc_pkg::CELL_BITS_DEF + $clog2(BOX_EDGE) + 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  fbc_pkg::plane_norm_t  normal,
    input  fbc_pkg::plane_off_t   offset,
    input  logic signed [P_W-1:0] p_lo [3],
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output logic [5:0]            negative
);
    import fbc_pkg::*;

    localparam int PROD_W = NORM_W + P_W;
    localparam int DIST_W = PROD_W + 2;
    localparam logic signed [P_W-1:0] EDGE_P = P_W'(BOX_EDGE);
    localparam logic signed [P_W-1:0] ZERO_P = '0;

    // Stage two
    logic                     s2_valid_reg;
    logic                     s2_ready;
    logic signed [PROD_W-1:0] prod_reg [NUM_PLANES][NUM_AXES];
    logic signed [PROD_W-1:0] prod_next [NUM_PLANES][NUM_AXES];
    plane_off_t               off_reg;

    // Stage three
    logic                     s3_valid_reg;
    logic                     s3_ready;
    logic [5:0]               neg_reg;
    logic [5:0]               neg_next;

    always_comb
    begin
        logic signed [NORM_W-1:0] n;
        logic signed [P_W-1:0]    p;
        for (int j = 0; j < NUM_PLANES; j++)
        begin
            for (int r = 0; r < NUM_AXES; r++)
            begin
                n = $signed(normal[j][r]);
                p = p_lo[r] + ((n > 0) ? EDGE_P : ZERO_P);
                prod_next[j][r] = PROD_W'(n) * PROD_W'(p);
            end
        end
    end

    assign s2_ready = !s2_valid_reg || s3_ready;
    assign up_ready = s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && s2_ready)
        begin
            prod_reg <= prod_next;
            off_reg  <= offset;
        end
    end

    always_comb
    begin
        logic signed [DIST_W-1:0] dist_sum;
        for (int j = 0; j < NUM_PLANES; j++)
        begin
            dist_sum = DIST_W'($signed(off_reg[j])) + DIST_W'(prod_reg[j][0]) +
                       DIST_W'(prod_reg[j][1]) + DIST_W'(prod_reg[j][2]);
            neg_next[j] = dist_sum[DIST_W-1];
        end
    end

    assign s3_ready = !s3_valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ready)
        begin
            neg_reg <= neg_next;
        end
    end

    assign dn_valid = s3_valid_reg;
    assign negative = neg_reg;

endmodule

// ===== rtl/frustum_box_cull.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_box_cull: view-frustum test of axis-aligned boxes
// Path: a test transaction's result is offered after passing four register stages.
// Throughput: one transaction per cycle, tests and loads alike; every stage
// holds its data under back-pressure and accepts again as soon as it drains.
// Reset clears the matrix to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module frustum_box_cull #(
    parameter int BOX_EDGE  = fbc_pkg::BOX_EDGE_DEF,
    parameter int CELL_BITS = fbc_pkg::CELL_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic                        operation,
    input  logic [1:0]                  group_index,
    input  logic signed [31:0]          entry_x,
    input  logic signed [31:0]          entry_y,
    input  logic signed [31:0]          entry_z,
    input  logic signed [31:0]          entry_w,
    input  logic signed [CELL_BITS-1:0] cell_x,
    input  logic signed [CELL_BITS-1:0] cell_y,
    input  logic signed [CELL_BITS-1:0] cell_z,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic                        visible
);
    import fbc_pkg::*;

    // Width of a far corner coordinate: it holds cell * BOX_EDGE + BOX_EDGE.
    localparam int P_W = CELL_BITS + $clog2(BOX_EDGE) + 2;

    // The pipeline runs in four register stages:
    //   1. plane formation from the matrix and scaling of the cell coordinate,
    //   2. far corner selection and one multiplier per normal component,
    //   3. a sum of three products and the offset for each of the six planes,
    //   4. the output register, which reports the box as culled if any of the
    //      six distances is negative.
    // A load transaction writes the matrix at acceptance and sends nothing down
    // the pipeline. Because a test transaction forms its planes in the same
    // cycle in which it is accepted, it sees exactly the loads that came before
    // it and none that follow.

    matrix_t               matrix;
    logic                  load_en;
    logic                  test_valid;
    logic                  form_ready;

    logic                  form_valid;
    logic                  dist_ready;
    plane_norm_t           normal;
    plane_off_t            offset;
    logic signed [P_W-1:0] p_lo [3];

    logic                  dist_valid;
    logic                  out_ready;
    logic [5:0]            negative;

    logic                  result_valid_reg;
    logic                  visible_reg;

    assign item_ready = form_ready;
    assign load_en    = item_valid && item_ready && (operation == OP_LOAD);
    assign test_valid = item_valid && (operation == OP_TEST);

    fbc_matrix_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (load_en),
        .wr_group (group_index),
        .wr_x     (entry_x),
        .wr_y     (entry_y),
        .wr_z     (entry_z),
        .wr_w     (entry_w),
        .matrix   (matrix)
    );

    fbc_plane_form #(
        .BOX_EDGE  (BOX_EDGE),
        .CELL_BITS (CELL_BITS),
        .P_W       (P_W)
    ) u_form (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (test_valid),
        .up_ready (form_ready),
        .matrix   (matrix),
        .cell_x   (cell_x),
        .cell_y   (cell_y),
        .cell_z   (cell_z),
        .dn_valid (form_valid),
        .dn_ready (dist_ready),
        .normal   (normal),
        .offset   (offset),
        .p_lo     (p_lo)
    );

    fbc_plane_dist #(
        .BOX_EDGE (BOX_EDGE),
        .P_W      (P_W)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (form_valid),
        .up_ready (dist_ready),
        .normal   (normal),
        .offset   (offset),
        .p_lo     (p_lo),
        .dn_valid (dist_valid),
        .dn_ready (out_ready),
        .negative (negative)
    );

    // The output register frees itself in the same cycle in which its result
    // is taken, so the pipeline keeps moving while the consumer accepts.
    assign out_ready = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            result_valid_reg <= dist_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dist_valid && out_ready)
        begin
            visible_reg <= (negative == 6'b000000);
        end
    end

    assign result_valid = result_valid_reg;
    assign visible      = visible_reg;

endmodule
